>>> rtl/core/chd_pkg.sv
`default_nettype none

package chd_pkg;

    localparam int FIELD_W            = 16;
    localparam int HEADING_W          = 9;
    localparam int X_W                = 20;
    localparam int Z_W                = 27;
    localparam int FRAC_W             = 16;
    localparam int DEG_W              = Z_W - FRAC_W;
    localparam int TABLE_LEN          = 24;
    localparam int ROTATION_STEPS_DEF = 16;

    localparam logic signed [Z_W-1:0] DEG_HALF_TURN = Z_W'(180 * 65536);
    localparam logic signed [Z_W-1:0] DEG_FULL_TURN = Z_W'(360 * 65536);
    localparam logic [DEG_W-1:0]      HEADING_MAX   = DEG_W'(359);

    typedef struct packed {
        logic                  zero;
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
    } t_vec;

    // atan(2^-i) in degrees, 16 fractional bits
    function automatic logic signed [Z_W-1:0] step_angle(input int step);
        logic signed [Z_W-1:0] a;
        case (step)
            0:  a = Z_W'(2949120);
            1:  a = Z_W'(1740967);
            2:  a = Z_W'(919879);
            3:  a = Z_W'(466945);
            4:  a = Z_W'(234379);
            5:  a = Z_W'(117304);
            6:  a = Z_W'(58666);
            7:  a = Z_W'(29335);
            8:  a = Z_W'(14668);
            9:  a = Z_W'(7334);
            10: a = Z_W'(3667);
            11: a = Z_W'(1833);
            12: a = Z_W'(917);
            13: a = Z_W'(458);
            14: a = Z_W'(229);
            15: a = Z_W'(115);
            16: a = Z_W'(57);
            17: a = Z_W'(29);
            18: a = Z_W'(14);
            19: a = Z_W'(7);
            20: a = Z_W'(4);
            21: a = Z_W'(2);
            22: a = Z_W'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/chd_rot_cell.sv
`default_nettype none

module chd_rot_cell #(
    parameter int STEP = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire chd_pkg::t_vec i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output chd_pkg::t_vec      o_data
);
    import chd_pkg::*;

    localparam logic signed [Z_W-1:0] ANGLE = step_angle(STEP);

    logic                  r_valid;
    t_vec                  r_data;
    t_vec                  n_data;
    logic signed [X_W-1:0] xs;
    logic signed [X_W-1:0] ys;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        xs          = i_data.x >>> STEP;
        ys          = i_data.y >>> STEP;
        n_data.zero = i_data.zero;
        if (!i_data.y[X_W-1]) begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + ANGLE;
        end else begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/compass_heading_degrees_core.sv
// path: registered input cell, one rotation cell per micro-rotation step, registered output cell
// throughput: one beat per cycle while the output is not stalled, one micro-rotation per cell of the chain
// stalls are passed back cell by cell, so bubbles in the chain are filled
// reset: synchronous, active low, clears the valid flags of every stage only
`default_nettype none

module compass_heading_degrees_core #(
    parameter int ROTATION_STEPS = chd_pkg::ROTATION_STEPS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [chd_pkg::FIELD_W-1:0]  i_field_x,
    input  wire logic signed [chd_pkg::FIELD_W-1:0]  i_field_y,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [chd_pkg::HEADING_W-1:0]            o_heading
);
    import chd_pkg::*;

    localparam int NSTEPS = (ROTATION_STEPS > TABLE_LEN) ? TABLE_LEN : ROTATION_STEPS;

    t_vec                  w_data  [NSTEPS+1];
    logic                  w_valid [NSTEPS+1];
    logic                  w_ready [NSTEPS+1];

    logic                  r_pre_valid;
    t_vec                  r_pre;
    t_vec                  n_pre;
    logic signed [X_W-1:0] xe;
    logic signed [X_W-1:0] ye;

    logic                  r_out_valid;
    logic [HEADING_W-1:0]  r_heading;
    logic [HEADING_W-1:0]  n_heading;
    logic signed [Z_W-1:0] z_wrap;
    logic [DEG_W-1:0]      deg;

    // input cell: zero test and fold into the right half-plane
    always_comb begin
        xe         = X_W'(i_field_x);
        ye         = X_W'(i_field_y);
        n_pre.zero = (i_field_x == '0) || (i_field_y == '0);
        if (i_field_x[FIELD_W-1]) begin
            n_pre.x = -xe;
            n_pre.y = -ye;
            n_pre.z = i_field_y[FIELD_W-1] ? -DEG_HALF_TURN : DEG_HALF_TURN;
        end else begin
            n_pre.x = xe;
            n_pre.y = ye;
            n_pre.z = '0;
        end
    end

    assign o_stall = r_pre_valid && !w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (!o_stall) begin
            r_pre_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_pre <= n_pre;
        end
    end

    assign w_data[0]  = r_pre;
    assign w_valid[0] = r_pre_valid;

    for (genvar k = 0; k < NSTEPS; k++) begin : g_cell
        chd_rot_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    // output cell: wrap, truncate, saturate, and force zero for a zero input
    always_comb begin
        z_wrap = w_data[NSTEPS].z[Z_W-1] ? (w_data[NSTEPS].z + DEG_FULL_TURN)
                                         : w_data[NSTEPS].z;
        deg    = z_wrap[Z_W-1] ? '0 : DEG_W'(z_wrap[Z_W-1:FRAC_W]);
        if (w_data[NSTEPS].zero) begin
            n_heading = '0;
        end else if (deg > HEADING_MAX) begin
            n_heading = HEADING_W'(HEADING_MAX);
        end else begin
            n_heading = HEADING_W'(deg);
        end
    end

    assign w_ready[NSTEPS] = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[NSTEPS]) begin
            r_out_valid <= w_valid[NSTEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_valid[NSTEPS] && w_ready[NSTEPS]) begin
            r_heading <= n_heading;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_heading = r_heading;

endmodule

`default_nettype wire

>>> rtl/core/chd_checker.sv
`default_nettype none

module chd_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_valid,
    input wire logic                                o_stall,
    input wire logic signed [chd_pkg::FIELD_W-1:0]  i_field_x,
    input wire logic signed [chd_pkg::FIELD_W-1:0]  i_field_y,
    input wire logic                                o_valid,
    input wire logic                                i_stall,
    input wire logic [chd_pkg::HEADING_W-1:0]       o_heading
);
    import chd_pkg::*;

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_heading <= HEADING_W'(359))
        else $error("heading out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_heading))
        else $error("stalled output beat changed");

    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output is free");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind compass_heading_degrees_core chd_checker u_chd_checker (.*);

`default_nettype wire

>>> test/compass_heading_checker.sv
`timescale 1ns / 1ps

module compass_heading_checker #(
    parameter int ROTATION_STEPS = chd_pkg::ROTATION_STEPS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    input  wire logic                                i_in_stall,
    input  wire logic signed [chd_pkg::FIELD_W-1:0]  i_field_x,
    input  wire logic signed [chd_pkg::FIELD_W-1:0]  i_field_y,
    input  wire logic                                i_out_valid,
    input  wire logic                                i_out_stall,
    input  wire logic [chd_pkg::HEADING_W-1:0]       i_heading,
    output int                                       o_pending,
    output int                                       o_errors
);

    localparam longint ONE_DEG   = 65536;
    localparam longint HALF_TURN = 180 * ONE_DEG;
    localparam longint FULL_TURN = 360 * ONE_DEG;

    localparam longint ROT_ANGLE [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct {
        logic signed [chd_pkg::FIELD_W-1:0] x;
        logic signed [chd_pkg::FIELD_W-1:0] y;
        logic [chd_pkg::HEADING_W-1:0]      heading;
    } t_heading_exp;

    t_heading_exp heading_fifo [$];

    function automatic logic [chd_pkg::HEADING_W-1:0] cordic_heading(
        input logic signed [chd_pkg::FIELD_W-1:0] fx,
        input logic signed [chd_pkg::FIELD_W-1:0] fy
    );
        longint vx;
        longint vy;
        longint acc;
        longint sx;
        longint sy;
        longint deg;
        vx  = fx;
        vy  = fy;
        acc = 0;
        if (vx == 0 || vy == 0)
            return '0;
        // left half-plane: flip the vector and start half a turn round
        if (vx < 0) begin
            acc = (vy > 0) ? HALF_TURN : -HALF_TURN;
            vx  = -vx;
            vy  = -vy;
        end
        for (int i = 0; i < ROTATION_STEPS && i < chd_pkg::TABLE_LEN; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0) begin
                vx  = vx + sy;
                vy  = vy - sx;
                acc = acc + ROT_ANGLE[i];
            end else begin
                vx  = vx - sy;
                vy  = vy + sx;
                acc = acc - ROT_ANGLE[i];
            end
        end
        if (acc < 0)
            acc = acc + FULL_TURN;
        if (acc < 0)
            acc = 0;
        deg = acc / ONE_DEG;
        if (deg > 359)
            deg = 359;
        return chd_pkg::HEADING_W'(deg);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_errors = o_errors + 1;
    endtask

    always @(posedge i_clk) begin
        t_heading_exp e;
        if (!i_rst_n) begin
            o_errors = 0;
            heading_fifo.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                e.x       = i_field_x;
                e.y       = i_field_y;
                e.heading = cordic_heading(i_field_x, i_field_y);
                heading_fifo.push_back(e);
            end
            if (i_out_valid && !i_out_stall) begin
                if (heading_fifo.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat, heading %0d", i_heading));
                end else begin
                    e = heading_fifo.pop_front();
                    if (i_heading !== e.heading)
                        report_mismatch($sformatf("heading %0d, expected %0d for x %0d y %0d",
                            i_heading, e.heading, e.x, e.y));
                end
            end
        end
        o_pending <= heading_fifo.size();
    end

endmodule

>>> test/compass_heading_degrees_core_tb.sv
`timescale 1ns / 1ps

module compass_heading_degrees_core_tb;

    localparam int STEPS       = chd_pkg::ROTATION_STEPS_DEF;
    localparam int LATENCY     = STEPS + 2;
    localparam int HOLD_CYCLES = 300;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic signed [chd_pkg::FIELD_W-1:0] field_x   = '0;
    logic signed [chd_pkg::FIELD_W-1:0] field_y   = '0;
    logic                               out_stall = 1'b0;
    logic                               in_stall;
    logic                               out_valid;
    logic [chd_pkg::HEADING_W-1:0]      heading;
    int                                 pending;
    int                                 errors;

    int tx_gap_max  = 0;
    int rx_wait_max = 0;
    int hold_req    = 0;
    int hold_done   = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    compass_heading_degrees_core #(
        .ROTATION_STEPS(STEPS)
    ) DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_valid  (in_valid),
        .o_stall  (in_stall),
        .i_field_x(field_x),
        .i_field_y(field_y),
        .o_valid  (out_valid),
        .i_stall  (out_stall),
        .o_heading(heading)
    );

    compass_heading_checker #(
        .ROTATION_STEPS(STEPS)
    ) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_stall (in_stall),
        .i_field_x  (field_x),
        .i_field_y  (field_y),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_heading  (heading),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic signed [chd_pkg::FIELD_W-1:0] random_field();
        logic signed [chd_pkg::FIELD_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = chd_pkg::FIELD_W'($urandom_range(0, 15)) - 16'sd8;
            2:       v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            3:       v = $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
            default: v = chd_pkg::FIELD_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic offer_sample(
        input logic signed [chd_pkg::FIELD_W-1:0] x,
        input logic signed [chd_pkg::FIELD_W-1:0] y
    );
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        field_x  <= x;
        field_y  <= y;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic offer_random(input int count);
        repeat (count) offer_sample(random_field(), random_field());
    endtask

    task automatic drain();
        @(negedge clk) in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // result side: per-beat wait, plus a long hold-off on request
    initial begin
        int n;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req != hold_done) begin
                @(negedge clk) out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = hold_req;
            end
            n = $urandom_range(0, rx_wait_max);
            if (n > 0) begin
                @(negedge clk) out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk) out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed: axes, extremes, half-planes and the wrap near 360
        tx_gap_max  = 3;
        rx_wait_max = 3;
        offer_sample(16'sd0, 16'sd0);
        offer_sample(16'sd0, 16'sd5);
        offer_sample(-16'sd5, 16'sd0);
        offer_sample(16'sh7fff, 16'sh7fff);
        offer_sample(16'sh8000, 16'sh8000);
        offer_sample(16'sh8000, 16'sh7fff);
        offer_sample(16'sh7fff, 16'sh8000);
        offer_sample(16'sd1, 16'sd1);
        offer_sample(-16'sd1, 16'sd1);
        offer_sample(-16'sd1, -16'sd1);
        offer_sample(16'sd1, -16'sd1);
        offer_sample(16'sh8000, 16'sd1);
        offer_sample(16'sh8000, -16'sd1);
        offer_sample(16'sh7fff, 16'sd1);
        offer_sample(16'sh7fff, -16'sd1);
        offer_sample(16'sd1, 16'sh7fff);
        offer_sample(16'sd1, 16'sh8000);
        offer_sample(-16'sd1, 16'sh7fff);
        offer_sample(-16'sd1, 16'sh8000);
        offer_sample(16'sd30000, -16'sd2);
        offer_sample(-16'sd30000, 16'sd2);

        // back to back on both sides
        tx_gap_max  = 0;
        rx_wait_max = 0;
        offer_random(300);
        drain();

        // long hold-off on the result side while beats keep coming
        hold_req = hold_req + 1;
        offer_random(200);

        tx_gap_max  = 12;
        rx_wait_max = 2;
        offer_random(250);

        tx_gap_max  = 2;
        rx_wait_max = 12;
        offer_random(250);

        tx_gap_max  = 12;
        rx_wait_max = 12;
        offer_random(300);

        drain();
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
